// ===== hdl/aarm_pkg.sv =====
package aarm_pkg;

   localparam int CordicSteps = 30;
   localparam int SqrtSteps   = 32;
   localparam int DivSteps    = 31;

   localparam logic signed [35:0] Q30One    = 36'sd1073741824;
   localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
   localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
   localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
   localparam logic signed [35:0] CordicGain = 36'sd652032874;

   typedef logic signed [35:0] wide_type;

   function automatic logic [29:0] atan_entry(input int idx);
      logic [29:0] val;
      case (idx)
         0: val = 30'd843314857;
         1: val = 30'd497837829;
         2: val = 30'd263043837;
         3: val = 30'd133525159;
         4: val = 30'd67021687;
         5: val = 30'd33543516;
         6: val = 30'd16775851;
         7: val = 30'd8388437;
         8: val = 30'd4194283;
         9: val = 30'd2097149;
         default: begin
            if (idx <= 30) begin
               val = 30'(64'd1 << (30 - idx));
            end else begin
               val = '0;
            end
         end
      endcase
      return val;
   endfunction

   // Everything that travels down the chain alongside the arithmetic.
   typedef struct packed {
      logic              vld;
      logic              ident;
      logic              neg_cos;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic [65:0]       rem;    // square root remainder / dividend bits for the divider
      logic [65:0]       rad;    // radicand being consumed
      logic [31:0]       root;   // length, unsigned Q4.28
      logic [30:0]       qx;
      logic [30:0]       qy;
      logic [30:0]       qz;
      logic [61:0]       nx;     // dividend remainders
      logic [61:0]       ny;
      logic [61:0]       nz;
      wide_type          cx;
      wide_type          cy;
      wide_type          cz;
   } carry_type;

   function automatic logic signed [35:0] mulq(input logic signed [35:0] p,
                                               input logic signed [35:0] q);
      logic signed [71:0] prod;
      prod = p * q + 72'sd536870912;
      return 36'(prod >>> 30);
   endfunction

endpackage

// ===== hdl/aarm_sqrt_cell.sv =====
// One restoring square root step: one result bit per cycle while en is high.
module aarm_sqrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  aarm_pkg::carry_type  c_in,
   output aarm_pkg::carry_type  c_out
);
   aarm_pkg::carry_type c_ff, c_in_w;
   logic [65:0] rem_t;
   logic [65:0] trial;

   always_comb begin
      c_in_w = c_in;
      rem_t  = {c_in.rem[63:0], c_in.rad[65:64]};
      trial  = {32'd0, c_in.root, 2'b01};
      c_in_w.rad = {c_in.rad[63:0], 2'b00};
      if (rem_t >= trial) begin
         c_in_w.rem  = rem_t - trial;
         c_in_w.root = {c_in.root[30:0], 1'b1};
      end else begin
         c_in_w.rem  = rem_t;
         c_in_w.root = {c_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.vld <= 1'b0;
      end else if (en) begin
         c_ff <= c_in_w;
      end
   end

   assign c_out = c_ff;
endmodule

// ===== hdl/aarm_div_cell.sv =====
// One restoring division step for all three axis components at once.
module aarm_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  aarm_pkg::carry_type  c_in,
   output aarm_pkg::carry_type  c_out
);
   aarm_pkg::carry_type c_ff, c_in_w;
   logic [62:0] tx, ty, tz, d;

   always_comb begin
      c_in_w = c_in;
      d  = {31'd0, c_in.root};
      tx = {c_in.nx, 1'b0};
      ty = {c_in.ny, 1'b0};
      tz = {c_in.nz, 1'b0};
      // the dividend bits enter from the top of rem (mag << 30)
      tx[0] = c_in.rem[65];
      ty[0] = c_in.rem[64];
      tz[0] = c_in.rem[63];
      c_in_w.rem = {c_in.rem[62:0], 3'b000};
      if (tx >= d) begin
         c_in_w.nx = 62'(tx - d);
         c_in_w.qx = {c_in.qx[29:0], 1'b1};
      end else begin
         c_in_w.nx = tx[61:0];
         c_in_w.qx = {c_in.qx[29:0], 1'b0};
      end
      if (ty >= d) begin
         c_in_w.ny = 62'(ty - d);
         c_in_w.qy = {c_in.qy[29:0], 1'b1};
      end else begin
         c_in_w.ny = ty[61:0];
         c_in_w.qy = {c_in.qy[29:0], 1'b0};
      end
      if (tz >= d) begin
         c_in_w.nz = 62'(tz - d);
         c_in_w.qz = {c_in.qz[29:0], 1'b1};
      end else begin
         c_in_w.nz = tz[61:0];
         c_in_w.qz = {c_in.qz[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.vld <= 1'b0;
      end else if (en) begin
         c_ff <= c_in_w;
      end
   end

   assign c_out = c_ff;
endmodule

// ===== hdl/aarm_cordic_cell.sv =====
// One CORDIC rotation step; the step number is fixed per instance by its input.
module aarm_cordic_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [5:0]           step,
   input  aarm_pkg::carry_type  c_in,
   output aarm_pkg::carry_type  c_out
);
   aarm_pkg::carry_type c_ff, c_in_w;
   aarm_pkg::wide_type  dx, dy, ang;

   always_comb begin
      c_in_w = c_in;
      dx  = c_in.cy >>> step;
      dy  = c_in.cx >>> step;
      ang = aarm_pkg::wide_type'({6'd0, aarm_pkg::atan_entry(int'(step))});
      if (!c_in.cz[35]) begin
         c_in_w.cx = c_in.cx - dx;
         c_in_w.cy = c_in.cy + dy;
         c_in_w.cz = c_in.cz - ang;
      end else begin
         c_in_w.cx = c_in.cx + dx;
         c_in_w.cy = c_in.cy - dy;
         c_in_w.cz = c_in.cz + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.vld <= 1'b0;
      end else if (en) begin
         c_ff <= c_in_w;
      end
   end

   assign c_out = c_ff;
endmodule

// ===== hdl/axis_angle_rotation_matrix.sv =====
// Channel   Direction  Payload
// req       in         tdata[95:0] = rot_x, rot_y, rot_z (Q3.28)
// rsp       out        tdata[287:0] = r00 .. r22 in row order (Q1.30)
// csr       in         identity_threshold, 31 bits
//
// One request enters per cycle. The chain holds 32 square root cells,
// 31 divider cells, one reduction stage, 30 CORDIC cells and three product
// stages. The whole chain advances only when the output register is free
// or being taken, so a stall at the result side holds every request in
// place. Reset is synchronous; it clears the valid flags and sets the
// identity threshold to 1.
module axis_angle_rotation_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // rot_x, rot_y, rot_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);
   localparam int NS = aarm_pkg::SqrtSteps;
   localparam int ND = aarm_pkg::DivSteps;
   localparam int NC = aarm_pkg::CordicSteps;

   logic [30:0] thresh_ff;
   logic        en;

   aarm_pkg::carry_type head;
   aarm_pkg::carry_type sq [NS+1];
   aarm_pkg::carry_type cr [NC+1];
   aarm_pkg::carry_type red_ff, red_in;

   // product stages
   logic p1_vld_ff, p2_vld_ff, out_vld_ff;
   logic p1_id_ff, p2_id_ff;
   aarm_pkg::wide_type ux_ff, uy_ff, uz_ff, s_ff, omc_ff;
   aarm_pkg::wide_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, s2_ff, omc2_ff;
   aarm_pkg::wide_type ux2_ff, uy2_ff, uz2_ff;
   logic [287:0] out_ff, out_in;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 31'd1;
      end else if (csr_valid) begin
         thresh_ff <= csr_data;
      end
   end

   // Load the chain: radicand is the exact sum of squares, which always fits
   // 64 bits. It is left-aligned so that the cells take its bit pairs from
   // the top down, one pair per cell.
   logic [31:0] ax, ay, az;
   logic [63:0] sumsq;
   always_comb begin
      ax = req_tdata[31] ? 32'(-req_tdata[31:0]) : req_tdata[31:0];
      ay = req_tdata[63] ? 32'(-req_tdata[63:32]) : req_tdata[63:32];
      az = req_tdata[95] ? 32'(-req_tdata[95:64]) : req_tdata[95:64];
      sumsq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
      head = '0;
      head.vld   = req_tvalid;
      head.rot_x = req_tdata[31:0];
      head.rot_y = req_tdata[63:32];
      head.rot_z = req_tdata[95:64];
      head.rad   = {sumsq, 2'b00};
   end

   assign sq[0] = head;
   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      aarm_sqrt_cell u_cell (.clock, .reset, .en, .c_in(sq[i]), .c_out(sq[i+1]));
   end

   // Prepare the divider for (|r| << 30) / len. Since |r| <= len, the
   // quotient fits 31 bits and every quotient bit above those is zero, so the
   // partial remainder starts as |r| >> 1 and the lowest bit of |r| enters
   // through the top of rem in the first cell; the other cells shift in zeros.
   // |r| reaches 2^31 only for the most negative input; that bit is placed
   // straight into the starting remainder.
   logic [30:0] mx, my, mz;
   aarm_pkg::carry_type dv_fix;
   always_comb begin
      mx = sq[NS].rot_x[31] ? 31'(-sq[NS].rot_x) : 31'(sq[NS].rot_x);
      my = sq[NS].rot_y[31] ? 31'(-sq[NS].rot_y) : 31'(sq[NS].rot_y);
      mz = sq[NS].rot_z[31] ? 31'(-sq[NS].rot_z) : 31'(sq[NS].rot_z);
      dv_fix = sq[NS];
      dv_fix.ident = (sq[NS].root == 32'd0) || (sq[NS].root < {1'b0, thresh_ff});
      if (dv_fix.ident) begin
         dv_fix.root = 32'd1;
      end
      dv_fix.qx = '0;
      dv_fix.qy = '0;
      dv_fix.qz = '0;
      dv_fix.nx = {31'd0, sq[NS].rot_x == 32'h8000_0000, 30'(mx >> 1)};
      dv_fix.ny = {31'd0, sq[NS].rot_y == 32'h8000_0000, 30'(my >> 1)};
      dv_fix.nz = {31'd0, sq[NS].rot_z == 32'h8000_0000, 30'(mz >> 1)};
      dv_fix.rem = '0;
      dv_fix.rem[65] = mx[0];
      dv_fix.rem[64] = my[0];
      dv_fix.rem[63] = mz[0];
   end

   aarm_pkg::carry_type dchain [ND+1];
   assign dchain[0] = dv_fix;
   for (genvar i = 0; i < ND; i++) begin : g_div
      aarm_div_cell u_cell (.clock, .reset, .en, .c_in(dchain[i]), .c_out(dchain[i+1]));
   end

   // Range reduction and CORDIC seed.
   aarm_pkg::wide_type a;
   always_comb begin
      red_in = dchain[ND];
      a = aarm_pkg::wide_type'({dchain[ND].root, 2'b00});
      if (a > aarm_pkg::Q30Pi) begin
         a = a - aarm_pkg::Q30TwoPi;
      end
      if (a > aarm_pkg::Q30Pi) begin
         a = a - aarm_pkg::Q30TwoPi;
      end
      red_in.neg_cos = 1'b0;
      if (a > aarm_pkg::Q30HalfPi) begin
         a = aarm_pkg::Q30Pi - a;
         red_in.neg_cos = 1'b1;
      end else if (a < -aarm_pkg::Q30HalfPi) begin
         a = -aarm_pkg::Q30Pi - a;
         red_in.neg_cos = 1'b1;
      end
      red_in.cx = aarm_pkg::CordicGain;
      red_in.cy = '0;
      red_in.cz = a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff.vld <= 1'b0;
      end else if (en) begin
         red_ff <= red_in;
      end
   end

   assign cr[0] = red_ff;
   for (genvar i = 0; i < NC; i++) begin : g_cordic
      aarm_cordic_cell u_cell (.clock, .reset, .en, .step(6'(i)),
                               .c_in(cr[i]), .c_out(cr[i+1]));
   end

   // Signed axis components and trig values.
   aarm_pkg::wide_type uxi, uyi, uzi, cosv;
   always_comb begin
      uxi  = cr[NC].rot_x[31] ? -aarm_pkg::wide_type'({5'd0, cr[NC].qx})
                              :  aarm_pkg::wide_type'({5'd0, cr[NC].qx});
      uyi  = cr[NC].rot_y[31] ? -aarm_pkg::wide_type'({5'd0, cr[NC].qy})
                              :  aarm_pkg::wide_type'({5'd0, cr[NC].qy});
      uzi  = cr[NC].rot_z[31] ? -aarm_pkg::wide_type'({5'd0, cr[NC].qz})
                              :  aarm_pkg::wide_type'({5'd0, cr[NC].qz});
      cosv = cr[NC].neg_cos ? -cr[NC].cx : cr[NC].cx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= cr[NC].vld;
      end
      if (en) begin
         p1_id_ff <= cr[NC].ident;
         ux_ff    <= uxi;
         uy_ff    <= uyi;
         uz_ff    <= uzi;
         s_ff     <= cr[NC].cy;
         omc_ff   <= aarm_pkg::Q30One - cosv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
      if (en) begin
         p2_id_ff <= p1_id_ff;
         xx_ff  <= aarm_pkg::mulq(ux_ff, ux_ff);
         yy_ff  <= aarm_pkg::mulq(uy_ff, uy_ff);
         zz_ff  <= aarm_pkg::mulq(uz_ff, uz_ff);
         xy_ff  <= aarm_pkg::mulq(ux_ff, uy_ff);
         xz_ff  <= aarm_pkg::mulq(ux_ff, uz_ff);
         yz_ff  <= aarm_pkg::mulq(uy_ff, uz_ff);
         ux2_ff <= ux_ff;
         uy2_ff <= uy_ff;
         uz2_ff <= uz_ff;
         s2_ff  <= s_ff;
         omc2_ff <= omc_ff;
      end
   end

   function automatic logic [31:0] sat(input aarm_pkg::wide_type v);
      if (v > aarm_pkg::Q30One) begin
         return 32'(aarm_pkg::Q30One);
      end else if (v < -aarm_pkg::Q30One) begin
         return 32'(-aarm_pkg::Q30One);
      end
      return 32'(v);
   endfunction

   aarm_pkg::wide_type m [9];
   always_comb begin
      m[0] = aarm_pkg::Q30One + aarm_pkg::mulq(omc2_ff, -(yy_ff + zz_ff));
      m[1] = aarm_pkg::mulq(omc2_ff, xy_ff) - aarm_pkg::mulq(s2_ff, uz2_ff);
      m[2] = aarm_pkg::mulq(omc2_ff, xz_ff) + aarm_pkg::mulq(s2_ff, uy2_ff);
      m[3] = aarm_pkg::mulq(omc2_ff, xy_ff) + aarm_pkg::mulq(s2_ff, uz2_ff);
      m[4] = aarm_pkg::Q30One + aarm_pkg::mulq(omc2_ff, -(xx_ff + zz_ff));
      m[5] = aarm_pkg::mulq(omc2_ff, yz_ff) - aarm_pkg::mulq(s2_ff, ux2_ff);
      m[6] = aarm_pkg::mulq(omc2_ff, xz_ff) - aarm_pkg::mulq(s2_ff, uy2_ff);
      m[7] = aarm_pkg::mulq(omc2_ff, yz_ff) + aarm_pkg::mulq(s2_ff, ux2_ff);
      m[8] = aarm_pkg::Q30One + aarm_pkg::mulq(omc2_ff, -(xx_ff + yy_ff));
      for (int k = 0; k < 9; k++) begin
         if (p2_id_ff) begin
            out_in[32*k +: 32] = (k % 4 == 0) ? 32'(aarm_pkg::Q30One) : 32'd0;
         end else begin
            out_in[32*k +: 32] = sat(m[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= p2_vld_ff;
      end
      if (en) begin
         out_ff <= out_in;
      end
   end
endmodule
